@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ sv/bbcr_pkg.sv @@
// ----------------------------------------------------------------------------
// bbcr_pkg
// shared types and constants of the blob centroid and radius block
// ----------------------------------------------------------------------------
package bbcr_pkg;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 9;
  localparam int COLS_W     = 11;
  localparam int OUT_W      = 10;
  localparam int SUM_W      = 40;
  localparam int CNT_W      = 21;
  localparam int DIV_CNT_W  = $clog2(SUM_W);
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(115);
  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(640);

  typedef enum logic [0:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_COLUMNS   = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_START,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ sv/bbcr_accum.sv @@
// ----------------------------------------------------------------------------
// bbcr_accum
// per-pixel thresholding, position counters, sums, count and extremes
// ----------------------------------------------------------------------------
module bbcr_accum import bbcr_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              clear,
  input  logic [PIX_W-1:0]  pixel,
  input  logic [THR_W-1:0]  threshold,
  input  logic [COLS_W-1:0] frame_columns,
  output logic [SUM_W-1:0]  col_sum,
  output logic [SUM_W-1:0]  row_sum,
  output logic [CNT_W-1:0]  fg_count,
  output logic [CW-1:0]     min_col,
  output logic [CW-1:0]     max_col,
  output logic [RW-1:0]     min_row,
  output logic [RW-1:0]     max_row
);

  localparam int AW = (CW + 1 > COLS_W) ? CW + 1 : COLS_W;

  logic [CW-1:0]    col_pos_r, col_pos_nxt;
  logic [RW-1:0]    row_pos_r, row_pos_nxt;
  logic [SUM_W-1:0] col_sum_r, col_sum_nxt;
  logic [SUM_W-1:0] row_sum_r, row_sum_nxt;
  logic [CNT_W-1:0] fg_count_r, fg_count_nxt;
  logic [CW-1:0]    min_col_r, min_col_nxt, max_col_r, max_col_nxt;
  logic [RW-1:0]    min_row_r, min_row_nxt, max_row_r, max_row_nxt;
  logic [AW-1:0]    act_cols;
  logic             fg;
  logic             col_wrap;
  logic             row_inc;

  // column count limited to 1..MAX_COLS
  always_comb begin
    if (frame_columns == '0) begin
      act_cols = AW'(1);
    end else if (AW'(frame_columns) > AW'(MAX_COLS)) begin
      act_cols = AW'(MAX_COLS);
    end else begin
      act_cols = AW'(frame_columns);
    end
  end

  assign fg       = {1'b0, pixel} >= threshold;
  assign col_wrap = (AW'(col_pos_r) + AW'(1)) >= act_cols;
  assign row_inc  = ((RW + 1)'(row_pos_r) + (RW + 1)'(1)) < (RW + 1)'(MAX_ROWS);

  always_comb begin
    col_pos_nxt  = col_pos_r;
    row_pos_nxt  = row_pos_r;
    col_sum_nxt  = col_sum_r;
    row_sum_nxt  = row_sum_r;
    fg_count_nxt = fg_count_r;
    min_col_nxt  = min_col_r;
    max_col_nxt  = max_col_r;
    min_row_nxt  = min_row_r;
    max_row_nxt  = max_row_r;
    if (clear) begin
      col_pos_nxt  = '0;
      row_pos_nxt  = '0;
      col_sum_nxt  = '0;
      row_sum_nxt  = '0;
      fg_count_nxt = '0;
      min_col_nxt  = '1;
      max_col_nxt  = '0;
      min_row_nxt  = '1;
      max_row_nxt  = '0;
    end else if (fire) begin
      if (fg) begin
        // first foreground pixel sets all four extremes
        if (fg_count_r == '0) begin
          min_col_nxt = col_pos_r;
          max_col_nxt = col_pos_r;
          min_row_nxt = row_pos_r;
          max_row_nxt = row_pos_r;
        end else begin
          if (col_pos_r < min_col_r) min_col_nxt = col_pos_r;
          if (col_pos_r > max_col_r) max_col_nxt = col_pos_r;
          if (row_pos_r < min_row_r) min_row_nxt = row_pos_r;
          if (row_pos_r > max_row_r) max_row_nxt = row_pos_r;
        end
        // saturated count freezes sums
        if (fg_count_r != CNT_MAX) begin
          col_sum_nxt  = col_sum_r + SUM_W'(col_pos_r);
          row_sum_nxt  = row_sum_r + SUM_W'(row_pos_r);
          fg_count_nxt = fg_count_r + CNT_W'(1);
        end
      end
      if (col_wrap) begin
        col_pos_nxt = '0;
        if (row_inc) row_pos_nxt = row_pos_r + RW'(1);
      end else begin
        col_pos_nxt = col_pos_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      col_sum_r  <= '0;
      row_sum_r  <= '0;
      fg_count_r <= '0;
      min_col_r  <= '1;
      max_col_r  <= '0;
      min_row_r  <= '1;
      max_row_r  <= '0;
    end else begin
      col_pos_r  <= col_pos_nxt;
      row_pos_r  <= row_pos_nxt;
      col_sum_r  <= col_sum_nxt;
      row_sum_r  <= row_sum_nxt;
      fg_count_r <= fg_count_nxt;
      min_col_r  <= min_col_nxt;
      max_col_r  <= max_col_nxt;
      min_row_r  <= min_row_nxt;
      max_row_r  <= max_row_nxt;
    end
  end

  assign col_sum  = col_sum_r;
  assign row_sum  = row_sum_r;
  assign fg_count = fg_count_r;
  assign min_col  = min_col_r;
  assign max_col  = max_col_r;
  assign min_row  = min_row_r;
  assign max_row  = max_row_r;

endmodule

@@ sv/bbcr_div.sv @@
// ----------------------------------------------------------------------------
// bbcr_div
// restoring divider, one quotient bit per cycle, keeps the low result bits
// ----------------------------------------------------------------------------
module bbcr_div import bbcr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output div_sts_t         sts,
  output logic [OUT_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]     dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     dvs_r, dvs_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [OUT_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 qbit;

  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign qbit  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top bit drops
      rem_nxt = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_nxt = {quo_r[OUT_W-2:0], qbit};
      dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

@@ sv/binary_blob_centroid_radius.sv @@
// ----------------------------------------------------------------------------
// binary_blob_centroid_radius
// thresholds a raster frame and reports foreground centroid and radius
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  tdata: pixel; tlast: frame end
//   out_     out  out_tvalid/out_tready tdata: col,row,radius; tuser: empty
//   cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// a pixel is taken every cycle while a frame streams in
// after the last pixel one shared serial divider forms both means, 40 steps
// each, then the result goes to the output register (an empty frame skips the divider);
// in_tready stays low until then and while the output register is full
// a result waiting on out_tready does not stop the next frame from streaming
// synchronous active-low reset clears control state and the accumulators
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_blob_centroid_radius import bbcr_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] pixel
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [9:0] center_col, [19:10] center_row,
                                            // [29:20] radius, [31:30] zero
  output logic                  out_tuser,  // [0] empty_res
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [COLS_W-1:0]     cfg_wdata
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int RDW = ((CW > RW) ? CW : RW) + 1;

  state_t            state_r, state_nxt;
  logic [THR_W-1:0]  threshold_r;
  logic [COLS_W-1:0] frame_columns_r;

  logic [SUM_W-1:0]  col_sum, row_sum;
  logic [CNT_W-1:0]  fg_count;
  logic [CW-1:0]     min_col, max_col;
  logic [RW-1:0]     min_row, max_row;
  logic              fire;
  logic              acc_clear;

  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [SUM_W-1:0]  div_dvd;
  logic [OUT_W-1:0]  div_quo;
  logic              in_div;

  logic [CW-1:0]     half_w;
  logic [RW-1:0]     half_h;
  logic [RDW-1:0]    rad_sum;

  logic [OUT_W-1:0]  res_col_r, res_col_nxt;
  logic [OUT_W-1:0]  res_row_r, res_row_nxt;
  logic [OUT_W-1:0]  res_rad_r, res_rad_nxt;
  logic              res_empty_r, res_empty_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_col_r, out_col_nxt;
  logic [OUT_W-1:0]  out_row_r, out_row_nxt;
  logic [OUT_W-1:0]  out_rad_r, out_rad_nxt;
  logic              out_empty_r, out_empty_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= THR_RESET;
      frame_columns_r <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: threshold_r     <= cfg_wdata[THR_W-1:0];
        CFG_COLUMNS:   frame_columns_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  assign in_tready = (state_r == ST_RUN);
  assign fire      = in_tvalid && in_tready;

  bbcr_accum #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .clear         (acc_clear),
    .pixel         (in_tdata[PIX_W-1:0]),
    .threshold     (threshold_r),
    .frame_columns (frame_columns_r),
    .col_sum       (col_sum),
    .row_sum       (row_sum),
    .fg_count      (fg_count),
    .min_col       (min_col),
    .max_col       (max_col),
    .min_row       (min_row),
    .max_row       (max_row)
  );

  assign div_dvd = (state_r == ST_START) ? col_sum : row_sum;

  bbcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (fg_count),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  assign in_div = (state_r == ST_DIV_COL) || (state_r == ST_DIV_ROW);

  // extremes are frozen while the divider runs
  assign half_w  = (max_col - min_col) >> 1;
  assign half_h  = (max_row - min_row) >> 1;
  assign rad_sum = (RDW'(half_w) + RDW'(half_h)) >> 1;

  always_comb begin
    state_nxt     = state_r;
    div_ctl.start = 1'b0;
    acc_clear     = 1'b0;
    res_col_nxt   = res_col_r;
    res_row_nxt   = res_row_r;
    res_rad_nxt   = res_rad_r;
    res_empty_nxt = res_empty_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_rad_nxt   = out_rad_r;
    out_empty_nxt = out_empty_r;
    case (state_r)
      ST_RUN: begin
        if (fire && in_tlast) state_nxt = ST_START;
      end
      ST_START: begin
        if (fg_count == '0) begin
          res_col_nxt   = '0;
          res_row_nxt   = '0;
          res_rad_nxt   = '0;
          res_empty_nxt = 1'b1;
          state_nxt     = ST_LOAD;
        end else begin
          res_rad_nxt   = OUT_W'(rad_sum);
          res_empty_nxt = 1'b0;
          div_ctl.start = 1'b1;
          state_nxt     = ST_DIV_COL;
        end
      end
      ST_DIV_COL: begin
        if (div_sts.done) begin
          res_col_nxt   = div_quo;
          div_ctl.start = 1'b1;
          state_nxt     = ST_DIV_ROW;
        end
      end
      ST_DIV_ROW: begin
        if (div_sts.done) begin
          res_row_nxt = div_quo;
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = res_col_r;
          out_row_nxt   = res_row_r;
          out_rad_nxt   = res_rad_r;
          out_empty_nxt = res_empty_r;
          acc_clear     = 1'b1;
          state_nxt     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_col_r   <= res_col_nxt;
    res_row_r   <= res_row_nxt;
    res_rad_r   <= res_rad_nxt;
    res_empty_r <= res_empty_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_rad_r   <= out_rad_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_rad_r, out_row_r, out_col_r};
  assign out_tuser  = out_empty_r;

  `ASSERT_RST(a_ready_div_idle, clk, rst_n, in_tready |-> !div_sts.busy, "ready while dividing")
  `ASSERT_RST(a_last_stalls, clk, rst_n, (fire && in_tlast) |=> !in_tready, "no stall at frame end")
  `ASSERT_RST(a_done_in_div, clk, rst_n, div_sts.done |-> in_div, "done outside divide states")
  `ASSERT_ALWAYS(a_empty_zero, clk, (out_tvalid && out_tuser) |-> (out_tdata == '0), "empty nonzero")

endmodule

@@ verif/blob_stats_checker.sv @@
// ----------------------------------------------------------------------------
// blob_stats_checker
// watches the pixel, result and register ports of the blob centroid block,
// keeps its own frame statistics per accepted pixel, forms the centroid,
// radius and empty flag at each frame end, and compares every accepted
// result field by field against the oldest pending frame
// ----------------------------------------------------------------------------
module blob_stats_checker import bbcr_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] pixel
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [9:0] center_col, [19:10] center_row,
                                            // [29:20] radius, [31:30] zero
  input  logic                  out_tuser,  // [0] empty_res
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [COLS_W-1:0]     cfg_wdata,
  output int                    errors,
  output int                    pending,
  output int                    pixels_seen,
  output int                    results_seen,
  output int                    empties_seen
);

  typedef struct packed {
    logic [OUT_W-1:0] center_col;
    logic [OUT_W-1:0] center_row;
    logic [OUT_W-1:0] radius;
    logic             empty_res;
  } blob_summary_t;

  logic [THR_W-1:0]  thr;
  logic [COLS_W-1:0] ncols;
  logic [9:0]        col_at;
  logic [9:0]        row_at;
  logic [SUM_W-1:0]  col_acc;
  logic [SUM_W-1:0]  row_acc;
  logic [CNT_W-1:0]  fg_n;
  logic [10:0]       left_c;
  logic [9:0]        right_c;
  logic [10:0]       top_r;
  logic [9:0]        bottom_r;

  blob_summary_t expected_blobs[$];

  task automatic start_frame();
    col_at   = '0;
    row_at   = '0;
    col_acc  = '0;
    row_acc  = '0;
    fg_n     = '0;
    left_c   = ncols;
    right_c  = '0;
    top_r    = 11'(MAX_ROWS);
    bottom_r = '0;
  endtask

  task automatic track_pixel(input logic [PIX_W-1:0] pix, input logic last);
    logic [9:0]    c;
    logic [9:0]    r;
    int            eff_cols;
    int            half_w;
    int            half_h;
    blob_summary_t res;
    c = col_at;
    r = row_at;
    if (pix >= thr) begin
      // first foreground pixel seeds all four extremes
      if (fg_n == '0) begin
        left_c   = {1'b0, c};
        right_c  = c;
        top_r    = {1'b0, r};
        bottom_r = r;
      end else begin
        if ({1'b0, c} < left_c) left_c = {1'b0, c};
        if (c > right_c) right_c = c;
        if ({1'b0, r} < top_r) top_r = {1'b0, r};
        if (r > bottom_r) bottom_r = r;
      end
      // saturated count freezes the sums, extremes keep moving
      if (fg_n != CNT_MAX) begin
        col_acc = col_acc + SUM_W'(c);
        row_acc = row_acc + SUM_W'(r);
        fg_n    = fg_n + 1'b1;
      end
    end
    eff_cols = (ncols == '0) ? 1 : ((int'(ncols) > MAX_COLS) ? MAX_COLS : int'(ncols));
    if (int'(c) + 1 >= eff_cols) begin
      col_at = '0;
      if (int'(row_at) + 1 < MAX_ROWS) row_at = row_at + 1'b1;
    end else begin
      col_at = c + 1'b1;
    end
    if (last) begin
      if (fg_n == '0) begin
        res = '{center_col: '0, center_row: '0, radius: '0, empty_res: 1'b1};
      end else begin
        half_w = (int'(right_c) - int'(left_c)) / 2;
        half_h = (int'(bottom_r) - int'(top_r)) / 2;
        res.center_col = OUT_W'(col_acc / fg_n);
        res.center_row = OUT_W'(row_acc / fg_n);
        res.radius     = OUT_W'((half_w + half_h) / 2);
        res.empty_res  = 1'b0;
      end
      expected_blobs.push_back(res);
      start_frame();
    end
  endtask

  always @(posedge clk) begin : watch
    blob_summary_t got;
    blob_summary_t want;
    if (!rst_n) begin
      thr   = THR_RESET;
      ncols = COLS_RESET;
      start_frame();
      expected_blobs.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.center_col = out_tdata[9:0];
        got.center_row = out_tdata[19:10];
        got.radius     = out_tdata[29:20];
        got.empty_res  = out_tuser;
        results_seen++;
        if (got.empty_res) empties_seen++;
        if (expected_blobs.size() == 0) begin
          $error("result with no frame pending: col %0d row %0d radius %0d empty %0d",
                 got.center_col, got.center_row, got.radius, got.empty_res);
          errors++;
        end else begin
          want = expected_blobs.pop_front();
          if (got.center_col !== want.center_col) begin
            $error("center_col mismatch: expected %0d, got %0d",
                   want.center_col, got.center_col);
            errors++;
          end
          if (got.center_row !== want.center_row) begin
            $error("center_row mismatch: expected %0d, got %0d",
                   want.center_row, got.center_row);
            errors++;
          end
          if (got.radius !== want.radius) begin
            $error("radius mismatch: expected %0d, got %0d", want.radius, got.radius);
            errors++;
          end
          if (got.empty_res !== want.empty_res) begin
            $error("empty_res mismatch: expected %0d, got %0d",
                   want.empty_res, got.empty_res);
            errors++;
          end
        end
      end
      // a pixel taken on the edge of a register write still sees the old value
      if (in_tvalid && in_tready) begin
        pixels_seen++;
        track_pixel(in_tdata[PIX_W-1:0], in_tlast);
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD: thr   = cfg_wdata[THR_W-1:0];
          CFG_COLUMNS:   ncols = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = expected_blobs.size();
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// streams short and long greyscale frames into the blob centroid block under
// a range of thresholds and row widths, with random gaps and stalls on both
// channels; the checker beside the block predicts and compares each result
// ----------------------------------------------------------------------------
module tb;
  import bbcr_pkg::*;

  localparam int MAX_COLS        = 1024;
  localparam int MAX_ROWS        = 1024;
  localparam int DRAIN_CYCLES    = 120;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PIXELS   = 320;
  localparam int PRESSURE_PIXELS = 60;
  localparam int PHASES          = 16;
  localparam int LONG_FRAME      = 1030;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [0:0]            cfg_index;
  logic [COLS_W-1:0]     cfg_wdata;

  int   errors;
  int   pending;
  int   pixels_seen;
  int   results_seen;
  int   empties_seen;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   cur_thr        = 115;
  int   reg_writes     = 0;
  logic hold_request   = 1'b0;
  logic hold_served    = 1'b0;

  always #5 clk = ~clk;

  binary_blob_centroid_radius #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  blob_stats_checker #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending), .pixels_seen(pixels_seen),
    .results_seen(results_seen), .empties_seen(empties_seen)
  );

  initial begin : limit
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls, plus one long hold-off counted here
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served = 1'b1;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] pick_pixel(int level);
    int v;
    case ($urandom_range(7))
      0:       v = 0;
      1:       v = 255;
      2, 3:    v = level + int'($urandom_range(2)) - 1;
      default: v = int'($urandom_range(255));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // called and returns at a falling edge
  task automatic offer_pixel(input logic [7:0] pix, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // all results in, then let a partly streamed frame or the divider settle
  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= COLS_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_THRESHOLD) cur_thr = value;
    reg_writes++;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  initial begin : stimulus
    int  len;
    int  sent;
    int  thr_v;
    int  cols_v;
    logic fg;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: threshold boundary, empty frame, one-pixel frame
    offer_pixel(8'd0, 1'b0);
    offer_pixel(8'd255, 1'b0);
    offer_pixel(8'd114, 1'b0);
    offer_pixel(8'd115, 1'b1);
    offer_pixel(8'd10, 1'b0);
    offer_pixel(8'd20, 1'b1);
    offer_pixel(8'd255, 1'b1);
    settle();
    // zero threshold: everything foreground; zero columns act as one
    write_reg(CFG_THRESHOLD, 0);
    write_reg(CFG_COLUMNS, 0);
    repeat (3) offer_pixel(8'd0, 1'b0);
    offer_pixel(8'd0, 1'b1);
    settle();
    // threshold past the pixel range, column count past the maximum
    write_reg(CFG_THRESHOLD, 256);
    write_reg(CFG_COLUMNS, 2047);
    offer_pixel(8'd255, 1'b0);
    offer_pixel(8'd255, 1'b1);
    settle();
    write_reg(CFG_THRESHOLD, 511);
    write_reg(CFG_COLUMNS, 1024);
    offer_pixel(8'd255, 1'b1);
    settle();
    // narrow the row mid-frame so the current column ends the row at once
    write_reg(CFG_THRESHOLD, 128);
    write_reg(CFG_COLUMNS, 3);
    offer_pixel(8'd200, 1'b0);
    offer_pixel(8'd0, 1'b0);
    offer_pixel(8'd90, 1'b0);
    offer_pixel(8'd255, 1'b0);
    offer_pixel(8'd10, 1'b0);
    settle();
    write_reg(CFG_COLUMNS, 2);
    offer_pixel(8'd130, 1'b0);
    offer_pixel(8'd255, 1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin thr_v = 0;   cols_v = 2047; end
        1: begin thr_v = 256; cols_v = 1;    end
        2: begin thr_v = 255; cols_v = 0;    end
        3: begin thr_v = 1;   cols_v = 1024; end
        4: begin thr_v = 511; cols_v = 2;    end
        5: begin thr_v = 115; cols_v = 5;    end
        default: begin
          thr_v  = $urandom_range(240, 20);
          cols_v = $urandom_range(24, 1);
        end
      endcase
      write_reg(CFG_THRESHOLD, thr_v);
      write_reg(CFG_COLUMNS, cols_v);
      set_idling(p % 4);
      // output held off while short frames keep arriving
      if (p == 8) hold_request <= 1'b1;
      sent = 0;
      while (sent < RANDOM_PIXELS / PHASES || (p == 8 && sent < PRESSURE_PIXELS)) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 4);
        for (int i = 0; i < len; i++) offer_pixel(pick_pixel(cur_thr), i == len - 1);
        sent += len;
        if ($urandom_range(11) == 0) wait_results();
      end
      // sometimes leave a frame open across the register change
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(6, 1)) offer_pixel(pick_pixel(cur_thr), 1'b0);
      end
      settle();
    end

    // tall frame: one pixel per row, past the last row, foreground near the bottom
    set_idling(0);
    write_reg(CFG_THRESHOLD, 128);
    write_reg(CFG_COLUMNS, 0);
    for (int i = 0; i < LONG_FRAME; i++) begin
      fg = (i >= 1000 && $urandom_range(1) == 1) || i == LONG_FRAME - 1;
      offer_pixel(fg ? 8'($urandom_range(255, 128)) : 8'($urandom_range(127)),
                  i == LONG_FRAME - 1);
    end
    settle();

    $display("streamed %0d pixels, checked %0d frame results, %0d of them empty",
             pixels_seen, results_seen, empties_seen);
    $display("%0d register writes incl. thresholds 0..511 and row widths 0..2047",
             reg_writes);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
